[hw/rtl/dstq_pkg.sv]
// Shared types and codes for the deadline-sorted timer queue.
`timescale 1ns / 1ps
package dstq_pkg;

  localparam int unsigned IdW   = 5;
  localparam int unsigned TimeW = 63;
  localparam int unsigned Slots = 32;
  localparam int unsigned CntW  = 6;
  localparam int unsigned DataW = 72;

  // Command codes carried in in_tuser
  localparam logic [1:0] OP_SCHED  = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  // Result kinds carried in out_tuser
  localparam logic [1:0] KIND_ACK     = 2'd0;
  localparam logic [1:0] KIND_EXPIRED = 2'd1;
  localparam logic [1:0] KIND_NEXT    = 2'd2;
  localparam logic [1:0] KIND_EMPTY   = 2'd3;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IdW-1:0]   expired_id;
    logic [TimeW-1:0] next_deadline;
    logic             last;
  } result_t;

endpackage

[hw/rtl/dstq_out_reg.sv]
// Output register for result transactions.
`timescale 1ns / 1ps
module dstq_out_reg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  dstq_pkg::result_t          push_res,
  output logic                       can_push,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [dstq_pkg::DataW-1:0] out_tdata,
  output logic [1:0]                 out_tuser,
  output logic                       out_tlast
);
  import dstq_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign can_push = !valid_r || out_tready;

  // Valid flag
  always_comb begin
    valid_nxt = valid_r;
    if (push) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (push) begin
      res_r <= push_res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = res_r.kind;
  assign out_tlast  = res_r.last;
  assign out_tdata  = {4'b0, res_r.next_deadline, res_r.expired_id};

endmodule

[hw/rtl/dstq_ctrl.sv]
// Sequencer with the list and deadline memories.
`timescale 1ns / 1ps
module dstq_ctrl #(
  parameter int unsigned NUM_TIMERS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [dstq_pkg::IdW-1:0] in_id,
  input  logic [dstq_pkg::TimeW-1:0] in_time,
  input  logic [1:0]               in_op,
  input  logic                     can_push,
  output logic                     push,
  output dstq_pkg::result_t        push_res
);
  import dstq_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_CHK    = 11'b00000000010,
    S_RM_RD  = 11'b00000000100,
    S_RM_DT  = 11'b00000001000,
    S_INS_RD = 11'b00000010000,
    S_INS_OR = 11'b00000100000,
    S_INS_DL = 11'b00001000000,
    S_UP_RD  = 11'b00010000000,
    S_UP_OR  = 11'b00100000000,
    S_UP_DL  = 11'b01000000000,
    S_EMIT   = 11'b10000000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [1:0]       op_r;
  logic [IdW-1:0]   id_r;
  logic [TimeW-1:0] tp_r;
  logic [CntW-1:0]  p_r, p_nxt;
  logic [CntW-1:0]  len_r, len_nxt;
  logic [IdW-1:0]   head_r, head_nxt;
  logic             found_r, found_nxt;
  logic [IdW-1:0]   carry_r, carry_nxt;
  logic [IdW-1:0]   e_r, e_nxt;
  logic [Slots-1:0] sched_r, sched_nxt;
  result_t          res_r, res_nxt;
  logic             ret_up_r, ret_up_nxt;
  logic             in_ok;
  logic             in_id_ok;

  // List memory (circular, head_r is list position 0) and deadline memory
  logic [IdW-1:0]   ord_mem [Slots];
  logic [TimeW-1:0] dl_mem  [Slots];
  logic [IdW-1:0]   ord_ra, ord_wa, ord_wd, ord_q_r;
  logic             ord_we;
  logic [IdW-1:0]   dl_ra;
  logic             dl_we;
  logic [TimeW-1:0] dl_q_r;
  logic [IdW-1:0]   pos_addr;

  assign pos_addr = head_r + p_r[IdW-1:0];

  always_ff @(posedge clk) begin
    ord_q_r <= ord_mem[ord_ra];
    if (ord_we) begin
      ord_mem[ord_wa] <= ord_wd;
    end
  end

  always_ff @(posedge clk) begin
    dl_q_r <= dl_mem[dl_ra];
    if (dl_we) begin
      dl_mem[id_r] <= tp_r;
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_ok     = in_tvalid && in_tready;
  assign in_id_ok  = 32'(in_id) < NUM_TIMERS;
  assign push_res  = res_r;

  // Next-state and datapath
  always_comb begin
    state_nxt  = state_r;
    p_nxt      = p_r;
    len_nxt    = len_r;
    head_nxt   = head_r;
    found_nxt  = found_r;
    carry_nxt  = carry_r;
    e_nxt      = e_r;
    sched_nxt  = sched_r;
    res_nxt    = res_r;
    ret_up_nxt = ret_up_r;
    push       = 1'b0;
    ord_ra     = pos_addr;
    ord_we     = 1'b0;
    ord_wa     = pos_addr;
    ord_wd     = id_r;
    dl_ra      = ord_q_r;
    dl_we      = 1'b0;
    res_nxt    = '{kind: KIND_ACK, expired_id: '0, next_deadline: '0, last: 1'b1};
    if (state_r == S_EMIT || state_r == S_IDLE) begin
      res_nxt = res_r;
    end
    unique case (state_r)
      S_IDLE: begin
        dl_ra = in_id;
        p_nxt     = '0;
        found_nxt = 1'b0;
        ret_up_nxt = 1'b0;
        if (in_ok) begin
          res_nxt   = '{kind: KIND_ACK, expired_id: '0, next_deadline: '0, last: 1'b1};
          state_nxt = S_EMIT;
          if (in_op == OP_SCHED && in_id_ok) begin
            state_nxt = S_CHK;
          end else if (in_op == OP_CANCEL && in_id_ok && sched_r[in_id]) begin
            state_nxt = S_RM_RD;
          end else if (in_op == OP_UPDATE) begin
            state_nxt = S_UP_RD;
          end
        end
      end
      // Same deadline again leaves everything alone
      S_CHK: begin
        if (sched_r[id_r] && dl_q_r == tp_r) begin
          state_nxt = S_EMIT;
        end else begin
          dl_we     = 1'b1;
          state_nxt = sched_r[id_r] ? S_RM_RD : S_INS_RD;
        end
      end
      // Removal: compact entries behind the match down by one
      S_RM_RD: begin
        if (p_r == len_r) begin
          len_nxt       = len_r - CntW'(1);
          sched_nxt[id_r] = 1'b0;
          p_nxt         = '0;
          found_nxt     = 1'b0;
          state_nxt     = (op_r == OP_SCHED) ? S_INS_RD : S_EMIT;
        end else begin
          state_nxt = S_RM_DT;
        end
      end
      S_RM_DT: begin
        ord_wa = pos_addr - IdW'(1);
        ord_wd = ord_q_r;
        if (found_r) begin
          ord_we = 1'b1;
        end else if (ord_q_r == id_r) begin
          found_nxt = 1'b1;
        end
        p_nxt     = p_r + CntW'(1);
        state_nxt = S_RM_RD;
      end
      // Insertion: scan for first deadline >= new one, then ripple a carry
      S_INS_RD: begin
        if (p_r == len_r) begin
          ord_we          = 1'b1;
          ord_wd          = found_r ? carry_r : id_r;
          len_nxt         = len_r + CntW'(1);
          sched_nxt[id_r] = 1'b1;
          state_nxt       = S_EMIT;
        end else begin
          state_nxt = S_INS_OR;
        end
      end
      S_INS_OR: begin
        e_nxt = ord_q_r;
        if (found_r) begin
          ord_we    = 1'b1;
          ord_wd    = carry_r;
          carry_nxt = ord_q_r;
          p_nxt     = p_r + CntW'(1);
          state_nxt = S_INS_RD;
        end else begin
          state_nxt = S_INS_DL;
        end
      end
      S_INS_DL: begin
        if (dl_q_r >= tp_r) begin
          ord_we    = 1'b1;
          carry_nxt = e_r;
          found_nxt = 1'b1;
        end
        p_nxt     = p_r + CntW'(1);
        state_nxt = S_INS_RD;
      end
      // Update: pop expired heads one by one
      S_UP_RD: begin
        ord_ra = head_r;
        if (len_r == '0) begin
          res_nxt    = '{kind: KIND_EMPTY, expired_id: '0, next_deadline: '0, last: 1'b1};
          ret_up_nxt = 1'b0;
          state_nxt  = S_EMIT;
        end else begin
          state_nxt = S_UP_OR;
        end
      end
      S_UP_OR: begin
        e_nxt     = ord_q_r;
        state_nxt = S_UP_DL;
      end
      S_UP_DL: begin
        if (dl_q_r <= tp_r) begin
          res_nxt    = '{kind: KIND_EXPIRED, expired_id: e_r, next_deadline: '0, last: 1'b0};
          head_nxt   = head_r + IdW'(1);
          len_nxt    = len_r - CntW'(1);
          sched_nxt[e_r] = 1'b0;
          ret_up_nxt = 1'b1;
        end else begin
          res_nxt    = '{kind: KIND_NEXT, expired_id: '0, next_deadline: dl_q_r, last: 1'b1};
          ret_up_nxt = 1'b0;
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (can_push) begin
          push      = 1'b1;
          state_nxt = ret_up_r ? S_UP_RD : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
      head_r  <= '0;
      sched_r <= '0;
      ret_up_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      head_r  <= head_nxt;
      sched_r <= sched_nxt;
      ret_up_r <= ret_up_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    p_r     <= p_nxt;
    found_r <= found_nxt;
    carry_r <= carry_nxt;
    e_r     <= e_nxt;
    res_r   <= res_nxt;
    if (in_ok) begin
      op_r <= in_op;
      id_r <= in_id;
      tp_r <= in_time;
    end
  end

endmodule

[hw/rtl/deadline_sorted_timer_queue.sv]
// Top level of the deadline-sorted timer queue.
//
//  channel | ports                  | tuser        | tdata (low bit up)
//  --------+------------------------+--------------+------------------------------
//  in      | in_tvalid/in_tready    | opcode[1:0]  | timer_id[4:0], time_point[62:0]
//  out     | out_tvalid/out_tready  | kind[1:0]    | expired_id[4:0], next_deadline[62:0]
//
// Schedule: check the stored deadline, walk the whole list to remove a rescheduled id,
// read order and deadline of each entry scanned up to the slot, ripple a carry through
// the entries behind it, then emit the ack. Update: read order, then deadline, then emit
// for each expired timer and for the next-deadline result (only a read and the emit when
// the list is empty); both memories have one read port and a registered read. Reset
// (rst_n low, synchronous) empties the list. One command at a time; a stalled out_tready holds the sequencer at emit.
`timescale 1ns / 1ps
module deadline_sorted_timer_queue #(
  parameter int unsigned NUM_TIMERS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // timer_id[4:0], time_point[67:5], zero pad
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // expired_id[4:0], next_deadline[67:5], zero pad
  output logic [1:0]  out_tuser,  // kind[1:0]
  output logic        out_tlast
);
  import dstq_pkg::*;

  logic    can_push;
  logic    push;
  result_t push_res;

  dstq_ctrl #(
    .NUM_TIMERS(NUM_TIMERS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_id    (in_tdata[4:0]),
    .in_time  (in_tdata[67:5]),
    .in_op    (in_tuser),
    .can_push (can_push),
    .push     (push),
    .push_res (push_res)
  );

  dstq_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_res  (push_res),
    .can_push  (can_push),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule
